// File: rtl/rac_pkg.sv
// Shared constants and types for the rational accumulator.
package rac_pkg;

    localparam int W = 32;

    localparam logic [2:0] FUNC_LOAD = 3'd0;
    localparam logic [2:0] FUNC_ADD  = 3'd1;
    localparam logic [2:0] FUNC_SUB  = 3'd2;
    localparam logic [2:0] FUNC_MUL  = 3'd3;
    localparam logic [2:0] FUNC_DIV  = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OVF  = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [63:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quot;
        logic [63:0] rem;
    } div_rsp_t;

endpackage

// File: rtl/rac_div.sv
// Shared 64-bit restoring divider, one quotient bit per cycle.
module rac_div (
    input  logic              clk,
    input  logic              rst_n,
    input  rac_pkg::div_req_t req,
    output rac_pkg::div_rsp_t rsp
);

    logic [63:0] q_reg, q_next;
    logic [63:0] r_reg, r_next;
    logic [63:0] d_reg, d_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [65:0] trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {1'b0, r_reg, q_reg[63]} - {2'b00, d_reg};
        if (req.start)
        begin
            q_next    = req.dividend;
            r_next    = '0;
            d_next    = req.divisor;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[65])
            begin
                r_next = trial[63:0];
                q_next = {q_reg[62:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[62:0], q_reg[63]};
                q_next = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = q_reg;
    assign rsp.rem  = r_reg;

endmodule

// File: rtl/rational_accumulator_alu.sv
// Rational accumulator: sequencer around a shared divider and multiplier.
// Divides go through the shared divider and multiplies through a shift-add loop;
// Euclid GCD loops dominate, so the time an item takes depends on the operands.
// Throughput: one word at a time; s_tready is low while a word is in work.
// Reset (rst_n low, asynchronous): stored fraction becomes 0/1, output empty.
module rational_accumulator_alu (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // func[2:0], operand_num[34:3], operand_den[66:35]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // result_num[31:0], result_den[63:32], status[65:64]
);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_PREP  = 12'b000000000010,
        S_GCD   = 12'b000000000100,
        S_GWAIT = 12'b000000001000,
        S_DIVQ  = 12'b000000010000,
        S_DWAIT = 12'b000000100000,
        S_MUL   = 12'b000001000000,
        S_MWAIT = 12'b000010000000,
        S_SUM   = 12'b000100000000,
        S_CHK   = 12'b001000000000,
        S_OUT   = 12'b010000000000,
        S_HOLD  = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;

    logic [31:0] accn_reg, accn_next;
    logic [31:0] accd_reg, accd_next;
    logic [2:0]  func_reg, func_next;
    logic        cneg_reg, cneg_next;
    logic [63:0] cmag_reg, cmag_next;
    logic [63:0] opd_reg,  opd_next;
    logic [1:0]  st_reg, st_next;
    logic        ovf_reg, ovf_next;
    // GCD working pair and result
    logic [63:0] ga_reg, ga_next;
    logic [63:0] gb_reg, gb_next;
    logic [63:0] g_reg, g_next;
    // scratch values and step counter
    logic [63:0] v_reg [0:5];
    logic [63:0] v_next [0:5];
    logic [3:0]  step_reg, step_next;
    logic        sneg_reg, sneg_next;
    // multiply operands
    logic [63:0] ma_reg, ma_next;
    logic [63:0] mb_reg, mb_next;
    logic [63:0] mp_reg, mp_next;
    logic        mo_reg, mo_next;
    logic        mlost_reg, mlost_next;
    logic [64:0] msum;
    // GCD return point and output holding registers
    logic [3:0]  ret_reg, ret_next;
    logic        ov_reg, ov_next;
    logic [31:0] on_reg, on_next;
    logic [31:0] od_reg, od_next;
    logic [1:0]  os_reg, os_next;

    rac_pkg::div_req_t dreq;
    rac_pkg::div_rsp_t drsp;

    rac_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = ov_reg;
    assign m_tdata  = {6'd0, os_reg, od_reg, on_reg};

    // Scratch map: v0 amag, v1 b, v2 x/num, v3 y/den, v4 dq/pn, v5 bq/pd
    // step within add: 0 gcd(b,d) 1 bq 2 dq 3 x 4 y 5 den, then sum 7 commit-gcd
    //   8 mag/g 9 den/g
    // step within mul/div: 0 g1 10 g2 11..14 quotients 15 num 6 den
    //   then commit steps 7,8,9 as above

    logic aneg;
    logic [63:0] amag64;

    always_comb
    begin
        aneg   = accn_reg[31];
        amag64 = aneg ? (64'd0 - {{32{accn_reg[31]}}, accn_reg})
                      : {32'd0, accn_reg};
    end

    always_comb
    begin
        state_next = state_reg;
        accn_next = accn_reg; accd_next = accd_reg;
        func_next = func_reg; cneg_next = cneg_reg; cmag_next = cmag_reg;
        opd_next = opd_reg; st_next = st_reg; ovf_next = ovf_reg;
        ga_next = ga_reg; gb_next = gb_reg; g_next = g_reg;
        for (int i = 0; i < 6; i++)
            v_next[i] = v_reg[i];
        step_next = step_reg; sneg_next = sneg_reg;
        ma_next = ma_reg; mb_next = mb_reg; ret_next = ret_reg;
        mp_next = mp_reg; mo_next = mo_reg; mlost_next = mlost_reg;
        msum = {1'b0, mp_reg} + {1'b0, ma_reg};
        ov_next = ov_reg; on_next = on_reg; od_next = od_reg; os_next = os_reg;
        dreq.start = 1'b0; dreq.dividend = ga_reg; dreq.divisor = gb_reg;

        if (ov_reg && m_tready)
            ov_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    func_next = s_tdata[2:0];
                    cneg_next = s_tdata[34];
                    cmag_next = s_tdata[34] ? {32'd0, 32'd0 - s_tdata[34:3]}
                                            : {32'd0, s_tdata[34:3]};
                    opd_next  = {32'd0, s_tdata[66:35]};
                    st_next   = rac_pkg::ST_OK;
                    ovf_next  = 1'b0;
                    step_next = '0;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                v_next[0] = amag64;
                v_next[1] = {32'd0, accd_reg};
                if (func_reg > rac_pkg::FUNC_DIV)
                    state_next = S_OUT;
                else if (opd_reg == 64'd0)
                begin
                    st_next = rac_pkg::ST_ZERO;
                    state_next = S_OUT;
                end
                else if (func_reg == rac_pkg::FUNC_LOAD)
                begin
                    v_next[2] = cmag_reg;
                    v_next[3] = opd_reg;
                    sneg_next = cneg_reg;
                    step_next = 4'd7;
                    ga_next = cmag_reg; gb_next = opd_reg;
                    state_next = S_GCD;
                end
                else if (func_reg == rac_pkg::FUNC_ADD || func_reg == rac_pkg::FUNC_SUB)
                begin
                    ga_next = {32'd0, accd_reg}; gb_next = opd_reg;
                    step_next = 4'd0;
                    state_next = S_GCD;
                end
                else
                begin
                    if (func_reg == rac_pkg::FUNC_DIV)
                    begin
                        if (cmag_reg == 64'd0)
                        begin
                            st_next = rac_pkg::ST_ZERO;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            v_next[4] = opd_reg; v_next[5] = cmag_reg;
                            ga_next = amag64; gb_next = cmag_reg;
                            state_next = S_GCD;
                        end
                    end
                    else
                    begin
                        v_next[4] = cmag_reg; v_next[5] = opd_reg;
                        ga_next = amag64; gb_next = opd_reg;
                        state_next = S_GCD;
                    end
                    step_next = 4'd0;
                    sneg_next = aneg ^ cneg_reg;
                end
            end
            S_GCD:
            begin
                if (gb_reg == 64'd0)
                begin
                    g_next = ga_reg;
                    state_next = S_DIVQ;
                    ret_next = step_reg;
                end
                else
                begin
                    dreq.start = 1'b1;
                    state_next = S_GWAIT;
                end
            end
            S_GWAIT:
            begin
                if (drsp.done)
                begin
                    ga_next = gb_reg;
                    gb_next = drsp.rem;
                    state_next = S_GCD;
                end
            end
            S_DIVQ:
            begin
                // g just found; sequence further steps
                state_next = S_SUM;
            end
            S_DWAIT:
            begin
                if (drsp.done)
                begin
                    unique case (step_reg)
                        4'd1: v_next[5] = drsp.quot;
                        4'd2: v_next[4] = drsp.quot;
                        4'd8: v_next[2] = drsp.quot;
                        4'd9: v_next[3] = drsp.quot;
                        4'd11: ga_next = drsp.quot;
                        4'd12: gb_next = drsp.quot;
                        4'd13: ma_next = drsp.quot;
                        4'd14: mb_next = drsp.quot;
                        default: ;
                    endcase
                    state_next = S_SUM;
                end
            end
            S_MUL:
            begin
                mp_next = '0;
                mo_next = 1'b0;
                mlost_next = 1'b0;
                state_next = S_MWAIT;
            end
            S_MWAIT:
            begin
                // shift-add: one multiplier bit per cycle until mb is exhausted
                if (mb_reg != 64'd0)
                begin
                    if (mb_reg[0])
                    begin
                        mp_next = msum[63:0];
                        if (msum[64] || mlost_reg)
                            mo_next = 1'b1;
                    end
                    mlost_next = mlost_reg | ma_reg[63];
                    ma_next = {ma_reg[62:0], 1'b0};
                    mb_next = {1'b0, mb_reg[63:1]};
                end
                else
                begin
                    if (mo_reg)
                        ovf_next = 1'b1;
                    unique case (step_reg)
                        4'd3: v_next[2] = mp_reg;
                        4'd4: v_next[3] = mp_reg;
                        4'd5: v_next[4] = mp_reg;
                        default: v_next[2] = mp_reg;
                    endcase
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                state_next = S_SUM;
                if (func_reg == rac_pkg::FUNC_ADD || func_reg == rac_pkg::FUNC_SUB)
                begin
                    unique case (step_reg)
                        4'd0:
                        begin
                            step_next = 4'd1;
                            dreq.start = 1'b1;
                            dreq.dividend = v_reg[1]; dreq.divisor = g_reg;
                            state_next = S_DWAIT;
                        end
                        4'd1:
                        begin
                            step_next = 4'd2;
                            dreq.start = 1'b1;
                            dreq.dividend = opd_reg; dreq.divisor = g_reg;
                            state_next = S_DWAIT;
                        end
                        4'd2:
                        begin
                            step_next = 4'd3;
                            ma_next = v_reg[0]; mb_next = v_reg[4];
                            state_next = S_MUL;
                        end
                        4'd3:
                        begin
                            step_next = 4'd4;
                            ma_next = cmag_reg; mb_next = v_reg[5];
                            state_next = S_MUL;
                        end
                        4'd4:
                        begin
                            step_next = 4'd5;
                            ma_next = v_reg[5]; mb_next = opd_reg;
                            state_next = S_MUL;
                        end
                        4'd5:
                        begin
                            // x=v2, y=v3, den=v4
                            if (ovf_reg)
                            begin
                                st_next = rac_pkg::ST_OVF;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                logic yneg;
                                logic [64:0] s;
                                yneg = (func_reg == rac_pkg::FUNC_SUB) ? !cneg_reg : cneg_reg;
                                s = '0;
                                if (aneg == yneg)
                                begin
                                    s = {1'b0, v_reg[2]} + {1'b0, v_reg[3]};
                                    sneg_next = aneg;
                                end
                                else if (v_reg[2] >= v_reg[3])
                                begin
                                    s = {1'b0, v_reg[2] - v_reg[3]};
                                    sneg_next = aneg;
                                end
                                else
                                begin
                                    s = {1'b0, v_reg[3] - v_reg[2]};
                                    sneg_next = yneg;
                                end
                                if (s[64])
                                begin
                                    st_next = rac_pkg::ST_OVF;
                                    state_next = S_OUT;
                                end
                                else
                                begin
                                    v_next[2] = s[63:0];
                                    v_next[3] = v_reg[4];
                                    ga_next = s[63:0]; gb_next = v_reg[4];
                                    step_next = 4'd7;
                                    state_next = S_GCD;
                                end
                            end
                        end
                        default: state_next = S_CHK;
                    endcase
                    if (step_reg >= 4'd7)
                        state_next = S_CHK;
                end
                else if (func_reg == rac_pkg::FUNC_LOAD)
                    state_next = S_CHK;
                else
                begin
                    // mul / div: g1 -> g2 -> quotients -> products
                    unique case (step_reg)
                        4'd0:
                        begin
                            v_next[1] = (g_reg == 64'd0) ? 64'd1 : g_reg; // g1 in v1
                            ga_next = v_reg[4]; gb_next = {32'd0, accd_reg};
                            step_next = 4'd10;
                            state_next = S_GCD;
                        end
                        4'd10:
                        begin
                            v_next[3] = (g_reg == 64'd0) ? 64'd1 : g_reg; // g2 in v3
                            step_next = 4'd11;
                            dreq.start = 1'b1;
                            dreq.dividend = v_reg[0]; dreq.divisor = v_reg[1];
                            state_next = S_DWAIT;
                        end
                        4'd11:
                        begin
                            step_next = 4'd12;
                            dreq.start = 1'b1;
                            dreq.dividend = v_reg[4]; dreq.divisor = v_reg[3];
                            state_next = S_DWAIT;
                        end
                        4'd12:
                        begin
                            step_next = 4'd13;
                            dreq.start = 1'b1;
                            dreq.dividend = {32'd0, accd_reg}; dreq.divisor = v_reg[3];
                            state_next = S_DWAIT;
                        end
                        4'd13:
                        begin
                            step_next = 4'd14;
                            dreq.start = 1'b1;
                            dreq.dividend = v_reg[5]; dreq.divisor = v_reg[1];
                            state_next = S_DWAIT;
                        end
                        4'd14:
                        begin
                            // ga=a/g1 gb=pn/g2 ma=b/g2 mb=pd/g1
                            v_next[0] = ma_reg;
                            v_next[1] = mb_reg;
                            ma_next = ga_reg; mb_next = gb_reg;
                            step_next = 4'd15;
                            state_next = S_MUL;
                        end
                        4'd15:
                        begin
                            // num in v2; den = v0 * v1
                            if (ovf_reg)
                            begin
                                st_next = rac_pkg::ST_OVF;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                v_next[5] = v_reg[2];
                                ma_next = v_reg[0]; mb_next = v_reg[1];
                                step_next = 4'd6;
                                state_next = S_MUL;
                            end
                        end
                        4'd6:
                        begin
                            // num in v5, den in v2
                            if (ovf_reg)
                            begin
                                st_next = rac_pkg::ST_OVF;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                v_next[3] = v_reg[2];
                                v_next[2] = v_reg[5];
                                ga_next = v_reg[5]; gb_next = v_reg[2];
                                step_next = 4'd7;
                                func_next = rac_pkg::FUNC_LOAD;
                                state_next = S_GCD;
                            end
                        end
                        default: state_next = S_CHK;
                    endcase
                end
            end
            S_CHK:
            begin
                // commit: g_reg is gcd(v2, v3); divide both then check
                unique case (step_reg)
                    4'd7:
                    begin
                        if (g_reg == 64'd0)
                        begin
                            st_next = rac_pkg::ST_ZERO;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            step_next = 4'd8;
                            dreq.start = 1'b1;
                            dreq.dividend = v_reg[2]; dreq.divisor = g_reg;
                            state_next = S_HOLD;
                        end
                    end
                    4'd8:
                    begin
                        step_next = 4'd9;
                        dreq.start = 1'b1;
                        dreq.dividend = v_reg[3]; dreq.divisor = g_reg;
                        state_next = S_HOLD;
                    end
                    default:
                    begin
                        logic n;
                        n = sneg_reg && (v_reg[2] != 64'd0);
                        if ((n ? (v_reg[2] > 64'h80000000) : (v_reg[2] > 64'h7FFFFFFF))
                            || v_reg[3][63:32] != 32'd0)
                            st_next = rac_pkg::ST_OVF;
                        else
                        begin
                            accn_next = n ? (32'd0 - v_reg[2][31:0]) : v_reg[2][31:0];
                            accd_next = v_reg[3][31:0];
                        end
                        state_next = S_OUT;
                    end
                endcase
            end
            S_HOLD:
            begin
                if (drsp.done)
                begin
                    if (step_reg == 4'd8)
                        v_next[2] = drsp.quot;
                    else
                        v_next[3] = drsp.quot;
                    state_next = S_CHK;
                end
            end
            S_OUT:
            begin
                if (!ov_reg || m_tready)
                begin
                    ov_next = 1'b1;
                    on_next = accn_next;
                    od_next = accd_next;
                    os_next = st_next;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        // GCD completion routes back by mode
        if (state_reg == S_DIVQ)
            state_next = (ret_reg >= 4'd7 && ret_reg <= 4'd9) ? S_CHK : S_SUM;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            accn_reg  <= '0;
            accd_reg  <= 32'd1;
            ov_reg    <= 1'b0;
            step_reg  <= '0;
            ovf_reg   <= 1'b0;
            st_reg    <= rac_pkg::ST_OK;
            func_reg  <= rac_pkg::FUNC_LOAD;
        end
        else
        begin
            state_reg <= state_next;
            accn_reg  <= accn_next;
            accd_reg  <= accd_next;
            ov_reg    <= ov_next;
            step_reg  <= step_next;
            ovf_reg   <= ovf_next;
            st_reg    <= st_next;
            func_reg  <= func_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cneg_reg <= cneg_next; cmag_reg <= cmag_next; opd_reg <= opd_next;
        ga_reg <= ga_next; gb_reg <= gb_next; g_reg <= g_next;
        for (int i = 0; i < 6; i++)
            v_reg[i] <= v_next[i];
        sneg_reg <= sneg_next; ma_reg <= ma_next; mb_reg <= mb_next;
        mp_reg <= mp_next; mo_reg <= mo_next; mlost_reg <= mlost_next;
        ret_reg <= ret_next; on_reg <= on_next; od_reg <= od_next; os_reg <= os_next;
    end

endmodule
